// ===== hdl/blocked_entry_timeout_table_core_macros.svh =====
// Assertion macros for the timeout table checker.
`ifndef BLOCKED_ENTRY_TIMEOUT_TABLE_CORE_MACROS_SVH
`define BLOCKED_ENTRY_TIMEOUT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BET_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bet assertion failed: name");

// Next-cycle implication, disabled while reset is asserted.
`define BET_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bet assertion failed: name");

`endif

// ===== hdl/bet_pkg.sv =====
// Types, codes and constants of the blocked-entry timeout table.
`timescale 1ns / 1ps

package bet_pkg;

    localparam int unsigned BET_CAPACITY = 16;
    localparam logic [31:0] LIMIT_RESET  = 32'd1000000;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_UNBLOCK = 2'd1,
        FUNC_REMOVE  = 2'd2,
        FUNC_SWEEP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STATUS_DONE      = 3'd0,
        STATUS_NOT_FOUND = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_EXPIRED   = 3'd3,
        STATUS_NONE      = 3'd4
    } status_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] txn_id;
        logic [31:0] time_now;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] result_id;
        logic        last;
    } out_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        do_op;     // add, unblock or remove transfer
        logic        do_sweep;  // sweep transfer
        logic        do_pop;    // emit lowest pending expired entry
        logic        found;     // some cell matches txn_id
        func_t       func;
        logic [31:0] txn_id;
        logic [31:0] time_now;
        logic [31:0] limit;
    } cmd_t;

    // Passed from each cell to the next, lowest slot first.
    typedef struct packed {
        logic        match_seen;
        logic        free_seen;
        logic        pend_seen;
        logic        extra_seen;
        logic [31:0] id_acc;
    } link_t;

endpackage

// ===== hdl/bet_cell.sv =====
// One table slot: id, start time, flags, and its link in the priority chain.
`timescale 1ns / 1ps

module bet_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  bet_pkg::cmd_t cmd,
    input  bet_pkg::link_t link_in,
    output bet_pkg::link_t link_out
);
    import bet_pkg::*;

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    logic        blocked_reg, blocked_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] start_reg, start_next;

    logic        match;
    logic        hit;
    logic        take;
    logic        pend_sel;
    logic        expired;
    logic [31:0] elapsed;

    assign match    = valid_reg && (id_reg == cmd.txn_id);
    assign hit      = match && !link_in.match_seen;
    assign take     = !valid_reg && !link_in.free_seen;
    assign pend_sel = pend_reg && !link_in.pend_seen;
    assign elapsed  = cmd.time_now - start_reg;
    assign expired  = valid_reg && blocked_reg && (elapsed > cmd.limit);

    assign link_out.match_seen = link_in.match_seen | match;
    assign link_out.free_seen  = link_in.free_seen | !valid_reg;
    assign link_out.pend_seen  = link_in.pend_seen | pend_reg;
    assign link_out.extra_seen = link_in.extra_seen | (pend_reg && link_in.pend_seen);
    assign link_out.id_acc     = link_in.id_acc | (pend_sel ? id_reg : 32'd0);

    always_comb begin
        valid_next   = valid_reg;
        pend_next    = pend_reg;
        blocked_next = blocked_reg;
        id_next      = id_reg;
        start_next   = start_reg;
        if (cmd.do_op) begin
            case (cmd.func)
                FUNC_ADD: begin
                    if (hit) begin
                        start_next = cmd.time_now;
                    end else if (!cmd.found && take) begin
                        valid_next   = 1'b1;
                        id_next      = cmd.txn_id;
                        start_next   = cmd.time_now;
                        blocked_next = 1'b1;
                    end
                end
                FUNC_UNBLOCK: begin
                    if (hit) begin
                        blocked_next = 1'b0;
                    end
                end
                FUNC_REMOVE: begin
                    if (hit) begin
                        valid_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.do_sweep) begin
            // drop expired entries now, hold the id for reporting
            pend_next = expired;
            if (expired) begin
                valid_next = 1'b0;
            end
        end
        if (cmd.do_pop && pend_sel) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        blocked_reg <= blocked_next;
        id_reg      <= id_next;
        start_reg   <= start_next;
    end

endmodule

// ===== hdl/blocked_entry_timeout_table_core.sv =====
// Top level of the blocked-entry timeout table: cell row, control and result register.
// Add, unblock and remove: result is registered in the cycle after the input transfer; the
//   next input is taken in the cycle that result is taken, so one item per cycle.
// Sweep: cells latch their expiry flags at the transfer, then one expired id per cycle,
//   paced by the single result register; input is held off until the last one is loaded.
// Id lookup and free-slot search run combinationally through the priority chain of cells.
// Reset (synchronous, aresetn low) clears slot valid flags and sets the limit to 1000000.
`timescale 1ns / 1ps

module blocked_entry_timeout_table_core #(
    parameter int unsigned CAPACITY = bet_pkg::BET_CAPACITY
) (
    input  logic           aclk,
    input  logic           aresetn,
    // input items
    input  logic           s_valid,
    output logic           s_ready,
    input  bet_pkg::in_t   s_data,
    // result items
    output logic           m_valid,
    input  logic           m_ready,
    output bet_pkg::out_t  m_data,
    // overtime limit register
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [31:0]    cfg_data
);
    import bet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] echo_id_reg, echo_id_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic        out_free;
    logic        accept;
    cmd_t        cmd;
    link_t       links [CAPACITY+1];

    // Configuration is always taken; the user writes it only while idle.
    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid) ? cfg_data : limit_reg;

    // The result register can load when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // Start of the priority chain: nothing seen below slot zero.
    assign links[0] = '0;

    assign cmd.do_op    = accept && (s_data.func != FUNC_SWEEP);
    assign cmd.do_sweep = accept && (s_data.func == FUNC_SWEEP);
    assign cmd.do_pop   = (state_reg == ST_SWEEP) && out_free && links[CAPACITY].pend_seen;
    assign cmd.found    = links[CAPACITY].match_seen;
    assign cmd.func     = s_data.func;
    assign cmd.txn_id   = s_data.txn_id;
    assign cmd.time_now = s_data.time_now;
    assign cmd.limit    = limit_reg;

    // Row of slot cells; each hands its link to the next higher slot.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bet_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
    end

    always_comb begin
        state_next   = state_reg;
        echo_id_next = echo_id_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.func)
                        FUNC_SWEEP: begin
                            // cells latch their expiry flags; report from next cycle
                            echo_id_next = s_data.txn_id;
                            state_next   = ST_SWEEP;
                        end
                        FUNC_ADD: begin
                            m_valid_next          = 1'b1;
                            m_data_next.result_id = s_data.txn_id;
                            m_data_next.last      = 1'b1;
                            m_data_next.status    =
                                (cmd.found || links[CAPACITY].free_seen) ?
                                STATUS_DONE : STATUS_FULL;
                        end
                        default: begin
                            m_valid_next          = 1'b1;
                            m_data_next.result_id = s_data.txn_id;
                            m_data_next.last      = 1'b1;
                            m_data_next.status    =
                                cmd.found ? STATUS_DONE : STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (links[CAPACITY].pend_seen) begin
                        // report the lowest pending id; last when no other remains
                        m_data_next.status    = STATUS_EXPIRED;
                        m_data_next.result_id = links[CAPACITY].id_acc;
                        m_data_next.last      = !links[CAPACITY].extra_seen;
                        if (!links[CAPACITY].extra_seen) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_data_next.status    = STATUS_NONE;
                        m_data_next.result_id = echo_id_reg;
                        m_data_next.last      = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge aclk) begin
        echo_id_reg <= echo_id_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/bet_checker.sv =====
// Port-level checks of the timeout table and their bind to the top level.
`timescale 1ns / 1ps
`include "blocked_entry_timeout_table_core_macros.svh"

module bet_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input bet_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input bet_pkg::out_t m_data
);
    import bet_pkg::*;

    logic        s_xfer;
    logic        op_xfer;
    logic        sweep_xfer;
    logic        m_plain;
    logic        op_ok;
    logic [31:0] s_id;

    assign s_xfer     = s_valid && s_ready;
    assign op_xfer    = s_xfer && (s_data.func != FUNC_SWEEP);
    assign sweep_xfer = s_xfer && (s_data.func == FUNC_SWEEP);
    assign m_plain    = m_valid && (m_data.status != STATUS_EXPIRED);
    assign op_ok      = m_valid && m_data.last;
    assign s_id       = s_data.txn_id;

    // a stalled result holds
    `BET_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // only expired-id reports may leave last low
    `BET_ASSERT_NOW(a_last_single, aclk, aresetn, m_plain, m_data.last)

    // non-sweep operations answer in the next cycle with the echoed id
    `BET_ASSERT_NEXT(a_op_answer, aclk, aresetn, op_xfer, op_ok && (m_data.result_id == $past(s_id)))

    // a sweep blocks further input while it reports
    `BET_ASSERT_NEXT(a_sweep_block, aclk, aresetn, sweep_xfer, !s_ready)

endmodule

bind blocked_entry_timeout_table_core bet_checker u_bet_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the blocked-entry timeout table: shadow table plus random traffic.
`timescale 1ns / 1ps

module tb;
    import bet_pkg::*;

    localparam int unsigned POOL_SIZE   = 20;   // more ids than slots, so the table fills
    localparam int unsigned HOLD_CYCLES = 400;  // long result back-pressure stretch
    localparam int unsigned PHASE_ITEMS = 25;

    // Shadow copy of the table. note_request() replays every accepted input transfer
    // against it and queues the results the block owes; check_result() retires them.
    class timeout_table_scoreboard;
        bit        slot_used    [BET_CAPACITY];
        bit [31:0] slot_owner   [BET_CAPACITY];
        bit [31:0] slot_since   [BET_CAPACITY];
        bit        slot_blocked [BET_CAPACITY];
        bit [31:0] overtime_limit;
        out_t      pending_results [$];
        int        mismatches;

        function new();
            overtime_limit = LIMIT_RESET;
            mismatches     = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void load_limit(bit [31:0] value);
            overtime_limit = value;
        endfunction

        // Lowest valid slot holding this id, or -1.
        function int find_entry(bit [31:0] id);
            for (int i = 0; i < BET_CAPACITY; i++)
                if (slot_used[i] && slot_owner[i] == id) return i;
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < BET_CAPACITY; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        function void owe_result(status_t status, bit [31:0] id, bit last);
            out_t r;
            r.status    = status;
            r.result_id = id;
            r.last      = last;
            pending_results = {pending_results, r};
        endfunction

        function void note_request(in_t req);
            int        slot;
            bit [31:0] elapsed;
            bit [31:0] expired_ids [$];
            slot = find_entry(req.txn_id);
            case (req.func)
                FUNC_ADD: begin
                    // A present id only moves its start time; the blocked flag stays.
                    if (slot < 0) begin
                        slot = find_free();
                        if (slot >= 0) begin
                            slot_used[slot]    = 1'b1;
                            slot_owner[slot]   = req.txn_id;
                            slot_blocked[slot] = 1'b1;
                        end
                    end
                    if (slot < 0) begin
                        owe_result(STATUS_FULL, req.txn_id, 1'b1);
                    end else begin
                        slot_since[slot] = req.time_now;
                        owe_result(STATUS_DONE, req.txn_id, 1'b1);
                    end
                end
                FUNC_UNBLOCK, FUNC_REMOVE: begin
                    if (slot < 0) begin
                        owe_result(STATUS_NOT_FOUND, req.txn_id, 1'b1);
                    end else begin
                        if (req.func == FUNC_UNBLOCK) slot_blocked[slot] = 1'b0;
                        else slot_used[slot] = 1'b0;
                        owe_result(STATUS_DONE, req.txn_id, 1'b1);
                    end
                end
                default: begin
                    // Sweep: walk blocked slots lowest first, drop those past the limit.
                    for (int i = 0; i < BET_CAPACITY; i++) begin
                        elapsed = req.time_now - slot_since[i];
                        if (slot_used[i] && slot_blocked[i] && elapsed > overtime_limit) begin
                            slot_used[i] = 1'b0;
                            expired_ids  = {expired_ids, slot_owner[i]};
                        end
                    end
                    if (expired_ids.size() == 0) begin
                        owe_result(STATUS_NONE, req.txn_id, 1'b1);
                    end else begin
                        foreach (expired_ids[k])
                            owe_result(STATUS_EXPIRED, expired_ids[k],
                                       k == expired_ids.size() - 1);
                    end
                end
            endcase
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d result_id %h last %0b",
                       got.status, got.result_id, got.last);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.result_id !== want.result_id) begin
                $error("result_id: expected %h, actual %h", want.result_id, got.result_id);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // Traffic shaping: idling is shared by the sender and the receiver; hold_request is the receiver's.
    bit          idling       = 1'b1;
    int          hold_request = 0;

    // Random stimulus state: a small id pool and a tick counter advanced per item.
    bit [31:0]   id_pool [POOL_SIZE];
    bit [31:0]   clock_ticks;
    bit [31:0]   tick_step;

    timeout_table_scoreboard sb = new();

    blocked_entry_timeout_table_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Observe every transfer at the edge where it happens. Values read here are the
    // pre-edge values, since the block and the drivers both update through NBAs.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_request(s_data);
            if (cfg_valid && cfg_ready) sb.load_limit(cfg_data);
        end
    end

    // Result side: draw a stall per result, or take one long hold when requested.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = idling ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic in_t op_item(func_t func, bit [31:0] id, bit [31:0] ticks);
        in_t item;
        item.func     = func;
        item.txn_id   = id;
        item.time_now = ticks;
        return item;
    endfunction

    // Mostly pool ids and a slowly advancing clock, so entries are found, updated and
    // expire; a few fully random ids and times as noise.
    function automatic in_t random_item();
        in_t item;
        int  pick;
        pick        = $urandom_range(0, 99);
        clock_ticks = clock_ticks + $urandom_range(0, tick_step);
        if (pick < 40)      item.func = FUNC_ADD;
        else if (pick < 55) item.func = FUNC_UNBLOCK;
        else if (pick < 70) item.func = FUNC_REMOVE;
        else                item.func = FUNC_SWEEP;
        item.txn_id   = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        item.time_now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ticks;
        // Retire a pool id now and then so stale entries get exercised too.
        if ($urandom_range(0, 19) == 0) id_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        return item;
    endfunction

    // Offer one item and return at the edge of its transfer. Valid stays high after the
    // transfer so that a back-to-back item follows without a bubble; a gap lowers it.
    task automatic send_item(in_t item);
        int gap;
        gap = idling ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid right after the last transfer and wait for every owed result. Wait for the
    // next edge first so the monitor has noted the last input transfer.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(bit [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        bit [31:0] base;
        bit [31:0] id_set [BET_CAPACITY];
        bit [31:0] phase_limit;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, limit at its reset value. Start near the top of the tick range
        // so elapsed time wraps. Fill every slot, including ids of all zeros and all ones.
        base = 32'hFFFF_FFF0;
        foreach (id_set[k]) begin
            if (k == 0)                     id_set[k] = 32'h0000_0000;
            else if (k == BET_CAPACITY - 1) id_set[k] = 32'hFFFF_FFFF;
            else                            id_set[k] = ($urandom & 32'hFFFF_FFF0) | 32'(k);
        end
        foreach (id_set[k]) send_item(op_item(FUNC_ADD, id_set[k], base));
        // Table full: a new id is dropped.
        send_item(op_item(FUNC_ADD, 32'h0000_0010, base));
        // Elapsed equal to the limit does not expire.
        send_item(op_item(FUNC_SWEEP, $urandom, base + LIMIT_RESET));
        // One tick more expires every slot: the longest run of results.
        send_item(op_item(FUNC_SWEEP, $urandom, base + LIMIT_RESET + 1));

        // Update of a present id, unblocked entries, absent ids.
        base = $urandom;
        send_item(op_item(FUNC_ADD,     32'h0000_0010, base));
        send_item(op_item(FUNC_ADD,     32'h0000_0020, base));
        send_item(op_item(FUNC_UNBLOCK, 32'h0000_0020, base));
        send_item(op_item(FUNC_ADD,     32'h0000_0020, base));      // stays unblocked
        send_item(op_item(FUNC_ADD,     32'h0000_0010, base + 7));  // moves start time
        send_item(op_item(FUNC_UNBLOCK, 32'h0000_0030, base));
        send_item(op_item(FUNC_REMOVE,  32'h0000_0030, base));
        send_item(op_item(FUNC_SWEEP,   $urandom, base + LIMIT_RESET + 3));
        send_item(op_item(FUNC_SWEEP,   $urandom, base + LIMIT_RESET + 8));
        send_item(op_item(FUNC_REMOVE,  32'h0000_0020, base));

        // Random phases, each under its own limit; the extremes come first.
        foreach (id_pool[k]) id_pool[k] = $urandom;
        clock_ticks = $urandom;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       phase_limit = 32'h0000_0000;
                1:       phase_limit = 32'hFFFF_FFFF;
                2:       phase_limit = 32'd100;
                3:       phase_limit = $urandom;
                4:       phase_limit = LIMIT_RESET;
                default: phase_limit = $urandom_range(1, 5000);
            endcase
            write_limit(phase_limit);
            // Advance the clock by up to about a quarter of the limit per item.
            tick_step = (phase_limit >> 2) + 1;
            idling    = (phase % 2 == 1);
            // Hold results off for a long stretch while items keep coming back to back.
            if (phase == 2) hold_request = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender mid-phase until the block has caught up.
                if (phase == 3 && n == PHASE_ITEMS / 2) drain_results();
                send_item(random_item());
            end
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
